[rtl/core/ctre_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctre_pkg: shared definitions for the colour round-trip error core
// Command and status groups between the controller and the datapath, and
// the constants of the transform.
// ----------------------------------------------------------------------------
package ctre_pkg;

  // Default bound on the number of chroma doublings.
  localparam int DEF_MAX_DOUBLINGS = 4;

  // Field widths.
  localparam int PIX_W = 8;
  localparam int K_W   = 3;
  localparam int REC_W = 11;
  localparam int ACC_W = 48;
  localparam int SQ_W  = 20;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 3 * PIX_W;
  localparam int OUT_BITS   = 3 * PIX_W + K_W + 3 * REC_W + 3 * ACC_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Controller to datapath: one strobe for each step of the sequence.
  typedef struct packed {
    logic load;
    logic dbl_step;
    logic quant;
    logic resc;
    logic recon;
    logic square;
    logic acc;
  } ctre_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dbl_more;
  } ctre_stat_t;

endpackage : ctre_pkg
`default_nettype wire

[rtl/core/ctre_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctre_ctrl: sequence controller
// Steps one pixel through load, chroma doubling, quantization, rescale,
// reconstruction, squaring and accumulation, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ctre_ctrl
  import ctre_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  input  wire ctre_stat_t stat,
  output ctre_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DBL   = 3'd1;
  localparam logic [2:0] S_QUANT = 3'd2;
  localparam logic [2:0] S_RESC  = 3'd3;
  localparam logic [2:0] S_RECON = 3'd4;
  localparam logic [2:0] S_SQ    = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;

  // Next state and step strobes.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DBL;
        end
      end
      S_DBL: begin
        if (stat.dbl_more) begin
          cmd.dbl_step = 1'b1;
        end else begin
          state_next = S_QUANT;
        end
      end
      S_QUANT: begin
        cmd.quant  = 1'b1;
        state_next = S_RESC;
      end
      S_RESC: begin
        cmd.resc   = 1'b1;
        state_next = S_RECON;
      end
      S_RECON: begin
        cmd.recon  = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid || m_tready) begin
          cmd.acc    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set when a result is loaded, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> (!out_valid || m_tready))
    else $error("result register overwritten");

  // A loaded result is offered in the next cycle.
  a_acc_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |=> m_tvalid)
    else $error("loaded result not offered");

  // An accepted item always enters the doubling step.
  a_accept_dbl: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DBL))
    else $error("accepted item did not start doubling");

endmodule : ctre_ctrl
`default_nettype wire

[rtl/core/ctre_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctre_datapath: transform, quantization and error accumulation
// Holds the working registers of one pixel, the three error accumulators
// and the result register; each step is started by the controller.
// ----------------------------------------------------------------------------
module ctre_datapath
  import ctre_pkg::*;
#(
  parameter int MAX_DOUBLINGS = DEF_MAX_DOUBLINGS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  in_restart,
  input  wire ctre_cmd_t             cmd,
  output ctre_stat_t                 stat,
  output logic [OUT_DATA_W-1:0]      out_data
);

  // Saturating accumulate, optionally from zero.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [SQ_W-1:0] sq,
                                               input logic clr);
    logic [ACC_W-1:0] base;
    logic [ACC_W:0]   sum;
    base = clr ? '0 : acc;
    sum  = {1'b0, base} + {{(ACC_W + 1 - SQ_W){1'b0}}, sq};
    return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  endfunction

  // Clamp a signed 10-bit value to 0..255.
  function automatic logic [7:0] clamp8(input logic signed [9:0] x);
    if (x < 0) begin
      return 8'd0;
    end else if (x > 10'sd255) begin
      return 8'd255;
    end
    return x[7:0];
  endfunction

  // Working registers.
  logic [7:0]              pr, pg, pb;
  logic                    restart;
  logic signed [9:0]       y;
  logic signed [7:0]       du, dv;
  logic [K_W-1:0]          k;
  logic [7:0]              cy, cu, cv;
  logic signed [7:0]       ru, rv;
  logic signed [REC_W-1:0] rec_r, rec_g, rec_b;
  logic signed [REC_W-1:0] err_r, err_g, err_b;
  logic [SQ_W-1:0]         sq_r, sq_g, sq_b;
  logic [ACC_W-1:0]        acc_red, acc_green, acc_blue;

  // Forward transform of the incoming pixel.
  logic [7:0]         in_r, in_g, in_b;
  logic signed [10:0] t;
  logic signed [10:0] q4w;
  logic signed [8:0]  bd;
  logic signed [8:0]  hw;
  logic signed [9:0]  y_f;

  always_comb begin
    in_r = in_data[7:0];
    in_g = in_data[15:8];
    in_b = in_data[23:16];
    t    = $signed({2'b00, in_g, 1'b0}) - $signed({3'b000, in_b}) - $signed({3'b000, in_r});
    // Division by four truncating toward zero.
    q4w  = (t + (t[10] ? 11'sd3 : 11'sd0)) >>> 2;
    y_f  = $signed({2'b00, in_g}) - $signed({{2{q4w[7]}}, q4w[7:0]});
    bd   = $signed({1'b0, in_b}) - $signed({1'b0, in_r});
    hw   = (bd + (bd[8] ? 9'sd1 : 9'sd0)) >>> 1;
  end

  // Doubling goes on while k is below MAX_DOUBLINGS and both deviations stay strictly inside -64..64.
  always_comb begin
    stat.dbl_more = ({1'b0, k} < 4'(MAX_DOUBLINGS)) &&
                    (du > -8'sd64) && (du < 8'sd64) &&
                    (dv > -8'sd64) && (dv < 8'sd64);
  end

  // Quantization: u to a multiple of 4, v to a multiple of 8, both rounded to nearest with ties up.
  logic signed [8:0] su, sv, qu, qv;
  logic signed [9:0] cu_w, cv_w;

  always_comb begin
    su   = {du[7], du} + 9'sd2;
    sv   = {dv[7], dv} + 9'sd4;
    qu   = {su[8:2], 2'b00};
    qv   = {sv[8:3], 3'b000};
    cu_w = {qu[8], qu} + 10'sd128;
    cv_w = {qv[8], qv} + 10'sd128;
  end

  // Rescale by 256 >> k with a rounding floor shift by 8.
  logic [8:0]         factor;
  logic signed [8:0]  cu_off, cv_off;
  logic signed [18:0] pu, pv;

  always_comb begin
    factor = 9'(9'd256 >> k);
    cu_off = $signed({1'b0, cu}) - 9'sd128;
    cv_off = $signed({1'b0, cv}) - 9'sd128;
    pu     = ($signed(cu_off) * $signed({1'b0, factor})) + 19'sd128;
    pv     = ($signed(cv_off) * $signed({1'b0, factor})) + 19'sd128;
  end

  // Inverse transform and per-channel error.
  logic signed [REC_W-1:0] rg_w, rr_w, rb_w, du2, dve;

  always_comb begin
    du2  = {{2{ru[7]}}, ru, 1'b0};
    dve  = {{3{rv[7]}}, rv};
    rg_w = $signed({3'b000, cy}) + $signed({{3{ru[7]}}, ru});
    rr_w = rg_w - du2 - dve;
    rb_w = rg_w - du2 + dve;
  end

  // Squares of the errors.
  logic signed [2*REC_W-1:0] p_r, p_g, p_b;

  always_comb begin
    p_r = err_r * err_r;
    p_g = err_g * err_g;
    p_b = err_b * err_b;
  end

  // Working register updates, one step at a time.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pr      <= in_r;
      pg      <= in_g;
      pb      <= in_b;
      restart <= in_restart;
      y       <= y_f;
      du      <= q4w[7:0];
      dv      <= hw[7:0];
      k       <= '0;
    end
    if (cmd.dbl_step) begin
      du <= {du[6:0], 1'b0};
      dv <= {dv[6:0], 1'b0};
      k  <= k + 1'b1;
    end
    if (cmd.quant) begin
      cy <= clamp8(y);
      cu <= clamp8(cu_w);
      cv <= clamp8(cv_w);
    end
    if (cmd.resc) begin
      ru <= pu[15:8];
      rv <= pv[15:8];
    end
    if (cmd.recon) begin
      rec_r <= rr_w;
      rec_g <= rg_w;
      rec_b <= rb_w;
      err_r <= rr_w - $signed({3'b000, pr});
      err_g <= rg_w - $signed({3'b000, pg});
      err_b <= rb_w - $signed({3'b000, pb});
    end
    if (cmd.square) begin
      sq_r <= p_r[SQ_W-1:0];
      sq_g <= p_g[SQ_W-1:0];
      sq_b <= p_b[SQ_W-1:0];
    end
  end

  // Error accumulators, cleared by reset; a restarting pixel starts them anew from its own error.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_red   <= '0;
      acc_green <= '0;
      acc_blue  <= '0;
    end else if (cmd.acc) begin
      acc_red   <= sat_add(acc_red, sq_r, restart);
      acc_green <= sat_add(acc_green, sq_g, restart);
      acc_blue  <= sat_add(acc_blue, sq_b, restart);
    end
  end

  // Result register, loaded together with the accumulators.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      out_data <= {{(OUT_DATA_W - OUT_BITS){1'b0}},
                   sat_add(acc_blue, sq_b, restart),
                   sat_add(acc_green, sq_g, restart),
                   sat_add(acc_red, sq_r, restart),
                   rec_b, rec_g, rec_r, k, cv, cu, cy};
    end
  end

endmodule : ctre_datapath
`default_nettype wire

[rtl/core/color_transform_roundtrip_error_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// color_transform_roundtrip_error_core: colour round trip with error sums
// Puts each RGB pixel through a lossy reversible colour transform round trip
// and keeps saturating sums of the squared reconstruction error.
// ----------------------------------------------------------------------------
// One pixel is worked on at a time. After acceptance it passes through the
// doubling loop, where k (0 to MAX_DOUBLINGS) is the number of chroma
// doublings: the doubling loop runs one doubling a cycle, and quantization,
// rescale, reconstruction, squaring and accumulation follow as five steps of
// the sequencer. A finished result waits in an output register, so the next
// pixel is accepted while it is still waiting; the sequence stalls only at
// its last step if the previous result has not yet been taken. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module color_transform_roundtrip_error_core
  import ctre_pkg::*;
#(
  parameter int MAX_DOUBLINGS = DEF_MAX_DOUBLINGS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Pixel input.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata, from bit 0: pix_red[7:0], pix_green[15:8], pix_blue[23:16].
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: restart[0].
  input  wire logic                  s_tuser,
  // Result output.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata, from bit 0: luma_code[7:0], chroma_u_code[15:8],
  // chroma_v_code[23:16], scale_shift[26:24], rec_red[37:27],
  // rec_green[48:38], rec_blue[59:49], err_sum_red[107:60],
  // err_sum_green[155:108], err_sum_blue[203:156], zero fill[207:204].
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  ctre_cmd_t  cmd;
  ctre_stat_t stat;

  // Sequence controller.
  ctre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  ctre_datapath #(
    .MAX_DOUBLINGS (MAX_DOUBLINGS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_tdata),
    .in_restart (s_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (m_tdata)
  );

endmodule : color_transform_roundtrip_error_core
`default_nettype wire
